/* hw/rtl/lpfifo_pkg.sv */
// ----------------------------------------------------------------------------
// lpfifo_pkg
// Shared types and constants for the length-prefixed packet FIFO.
// ----------------------------------------------------------------------------
package lpfifo_pkg;

    localparam int Depth = 512;
    localparam int AW    = $clog2(Depth);

    localparam logic [7:0] LEN_CAP = 8'd255;
    localparam logic [7:0] MIN_LEN = 8'd5;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;
    localparam logic [1:0] OP_PULL  = 2'd3;

    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_DROPPED    = 3'd1;
    localparam logic [2:0] ST_NOT_READY  = 3'd2;
    localparam logic [2:0] ST_VALID      = 3'd3;
    localparam logic [2:0] ST_DISCARDED  = 3'd4;
    localparam logic [2:0] ST_NO_PAYLOAD = 3'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] packet_id;
        logic [7:0]  tx_byte;
        logic        last;
    } t_out_word;

endpackage

/* hw/rtl/lpfifo_ram.sv */
// ----------------------------------------------------------------------------
// lpfifo_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpfifo_ram #(
    parameter int Width = 8,
    parameter int Depth = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/lpfifo_front.sv */
// ----------------------------------------------------------------------------
// lpfifo_front
// Input stage: registers one word and holds it until the back end takes it.
// ----------------------------------------------------------------------------
module lpfifo_front
    import lpfifo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    output logic     o_valid,
    input  logic     i_ready,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // One-entry queue between the port and the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

/* hw/rtl/lpfifo_back.sv */
// ----------------------------------------------------------------------------
// lpfifo_back
// Sequencer: carries out one operation on the byte store and its pointers.
// ----------------------------------------------------------------------------
module lpfifo_back
    import lpfifo_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_HDR   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PUT2  = 3'd4;

    logic [2:0]    r_state;
    t_in_word      r_cmd;
    logic [AW-1:0] r_wp, r_rp, r_slot;
    logic [AW:0]   r_fill;
    logic          r_open;
    logic [7:0]    r_plen, r_left, r_len;
    logic [3:0]    r_hcnt;
    logic [7:0]    r_i0, r_i1, r_i2;
    logic [7:0]    r_drain;
    logic          r_ovalid;
    t_out_word     r_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    // Read address follows the read pointer; the RAM registers the read data.
    assign raddr = r_rp;

    lpfifo_ram #(.Width(8), .Depth(Depth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic full;
    assign full    = (r_fill == (AW+1)'(Depth));
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_word  = r_out;

    // Memory write selection.
    always_comb begin
        we    = 1'b0;
        waddr = r_wp;
        wdata = r_cmd.data;
        if (r_state == S_EXEC && r_cmd.op == OP_PUT && !r_open && !full) begin
            we    = 1'b1;
            wdata = 8'd0;
        end else if ((r_state == S_EXEC && r_cmd.op == OP_PUT && r_open
                      && r_plen != LEN_CAP && !full) ||
                     (r_state == S_PUT2 && !full)) begin
            we = 1'b1;
        end else if (r_state == S_EXEC && r_cmd.op == OP_END && r_open) begin
            we    = 1'b1;
            waddr = r_slot;
            wdata = r_plen;
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_fill   <= '0;
            r_open   <= 1'b0;
            r_slot   <= '0;
            r_plen   <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd   <= i_word;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out    <= '{status: ST_ACCEPTED, packet_id: 16'd0,
                                  tx_byte: 8'd0, last: 1'b0};
                    r_state  <= S_IDLE;
                    r_ovalid <= 1'b1;
                    case (r_cmd.op)
                        OP_PUT: begin
                            if (!r_open) begin
                                if (full) begin
                                    r_out.status <= ST_DROPPED;
                                end else begin
                                    r_slot   <= r_wp;
                                    r_plen   <= 8'd1;
                                    r_open   <= 1'b1;
                                    r_wp     <= r_wp + 1'b1;
                                    r_fill   <= r_fill + 1'b1;
                                    r_ovalid <= 1'b0;
                                    r_state  <= S_PUT2;
                                end
                            end else if (r_plen == LEN_CAP || full) begin
                                r_out.status <= ST_DROPPED;
                            end else begin
                                r_wp   <= r_wp + 1'b1;
                                r_fill <= r_fill + 1'b1;
                                r_plen <= r_plen + 8'd1;
                            end
                        end
                        OP_END: begin
                            if (r_open) begin
                                r_open <= 1'b0;
                                r_plen <= 8'd0;
                            end else begin
                                r_out.status <= ST_NOT_READY;
                            end
                        end
                        OP_CHECK: begin
                            if (r_left != 8'd0 || r_fill == '0) begin
                                r_out.status <= ST_NOT_READY;
                            end else begin
                                r_ovalid <= 1'b0;
                                r_hcnt   <= 4'd0;
                                r_state  <= S_HDR;
                            end
                        end
                        default: begin
                            if (r_left == 8'd0) begin
                                r_out.status <= ST_NO_PAYLOAD;
                            end else begin
                                r_out.tx_byte <= rdata;
                                r_out.last    <= (r_left == 8'd1);
                                r_left        <= r_left - 8'd1;
                                r_rp          <= r_rp + 1'b1;
                                r_fill        <= r_fill - 1'b1;
                            end
                        end
                    endcase
                end
                S_PUT2: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                    r_out    <= '{status: ST_ACCEPTED, packet_id: 16'd0,
                                  tx_byte: 8'd0, last: 1'b0};
                    if (full) begin
                        r_out.status <= ST_DROPPED;
                    end else begin
                        r_wp   <= r_wp + 1'b1;
                        r_fill <= r_fill + 1'b1;
                        r_plen <= 8'd2;
                    end
                end
                S_HDR: begin
                    // Even steps read a header byte; odd steps wait for the
                    // read data at the advanced pointer.
                    r_hcnt <= r_hcnt + 4'd1;
                    r_out  <= '{status: ST_DISCARDED, packet_id: 16'd0,
                                tx_byte: 8'd0, last: 1'b0};
                    case (r_hcnt)
                        4'd0: begin
                            r_len <= rdata;
                            if (rdata == 8'd0) begin
                                r_out.status <= ST_NOT_READY;
                                r_ovalid     <= 1'b1;
                                r_state      <= S_IDLE;
                            end else if (rdata < MIN_LEN) begin
                                r_drain <= rdata;
                                r_state <= S_DRAIN;
                            end else begin
                                r_rp   <= r_rp + 1'b1;
                                r_fill <= r_fill - 1'b1;
                            end
                        end
                        4'd2: begin
                            r_i0   <= rdata;
                            r_rp   <= r_rp + 1'b1;
                            r_fill <= r_fill - 1'b1;
                        end
                        4'd4: begin
                            r_i1   <= rdata;
                            r_rp   <= r_rp + 1'b1;
                            r_fill <= r_fill - 1'b1;
                        end
                        4'd6: begin
                            r_i2   <= rdata;
                            r_rp   <= r_rp + 1'b1;
                            r_fill <= r_fill - 1'b1;
                        end
                        4'd8: begin
                            r_rp   <= r_rp + 1'b1;
                            r_fill <= r_fill - 1'b1;
                            if ((r_i0 ^ r_i2) != 8'hFF || (r_i1 ^ rdata) != 8'hFF) begin
                                r_drain <= r_len - MIN_LEN;
                                r_state <= S_DRAIN;
                            end else begin
                                r_out.status    <= ST_VALID;
                                r_out.packet_id <= {r_i0, r_i1};
                                r_left          <= r_len - MIN_LEN;
                                r_ovalid        <= 1'b1;
                                r_state         <= S_IDLE;
                            end
                        end
                        default: begin
                            // Wait for the read data at the advanced pointer to settle.
                        end
                    endcase
                end
                S_DRAIN: begin
                    // Drop the rest of a bad packet, one byte a cycle.
                    if (r_drain == 8'd0 || r_fill == '0) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_drain <= r_drain - 8'd1;
                        r_rp    <= r_rp + 1'b1;
                        r_fill  <= r_fill - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The fill count never exceeds the store depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill <= (AW+1)'(Depth))
        else $error("fill count above depth");
    // A result is only raised when the sequencer returns to idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> r_state == S_IDLE)
        else $error("result raised outside idle");
    // An armed payload implies no header check is in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HDR |-> $past(r_left) == 8'd0 || $past(r_state) == S_HDR
        || $past(r_state) == S_EXEC)
        else $error("header check with payload armed");

endmodule

/* hw/rtl/length_prefixed_packet_fifo.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_fifo
// Byte ring FIFO that frames packets with a length prefix and id check.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. A word reaches the
// sequencer through a one-word input queue, and the sequencer registers its
// result. A put, end or pull takes the word, carries it out and hands off the
// result; the put that opens a packet stores the length byte and the data
// byte in turn. A head check of a packet of five bytes or more reads its five
// header bytes through the registered read port of the byte store, each in a
// step of its own, with a step between reads in which the read at the next
// address settles. A bad id then drops the remaining bytes of the packet; a
// packet shorter than five bytes is dropped whole after its length byte is
// read. An output stall holds the sequencer for as long as it lasts.
module length_prefixed_packet_fifo
    import lpfifo_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic     q_valid, q_ready;
    t_in_word q_word;

    lpfifo_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_word (i_word),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_word (q_word)
    );

    lpfifo_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_word (q_word),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_word (o_word)
    );

endmodule

/* bench/length_prefixed_packet_fifo_tb.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_fifo_tb
// Self-checking bench for the length-prefixed packet FIFO. A behavioral
// model of the byte ring predicts the result word for every accepted input
// word. A separate process checks each result word in order and stalls the
// output at random, with one long hold-off at the start of the full-ring test.
// ----------------------------------------------------------------------------
module length_prefixed_packet_fifo_tb;
    import lpfifo_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_word;

    length_prefixed_packet_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_word)
    );

    // Model state of the byte ring and the packet framing.
    logic [7:0] ring_mem [Depth];
    logic [8:0] wr_ptr;
    logic [8:0] rd_ptr;
    int         ring_fill;
    logic       pkt_open;
    logic [8:0] len_slot;
    int         pkt_len;
    int         pay_left;

    t_out_word  result_q [$];
    int         errors;
    bit         no_idle;
    bit         hold_start;
    int         hold_cnt;
    int         stall_cnt;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Global time limit.
    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    // Store one byte in the ring; false when the ring is full.
    function automatic bit ring_push(logic [7:0] b);
        if (ring_fill >= Depth) begin
            return 1'b0;
        end
        ring_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 9'd1;
        ring_fill++;
        pkt_len++;
        return 1'b1;
    endfunction

    // Take one byte from the ring head.
    function automatic logic [7:0] ring_pop();
        logic [7:0] b;
        if (ring_fill == 0) begin
            return 8'd0;
        end
        b = ring_mem[rd_ptr];
        rd_ptr = rd_ptr + 9'd1;
        ring_fill--;
        return b;
    endfunction

    // Drop up to n bytes from the ring head.
    function automatic void ring_drop(int n);
        logic [7:0] b;
        while (n > 0 && ring_fill > 0) begin
            b = ring_pop();
            n--;
        end
    endfunction

    // Compute the result word for one input word and update the model.
    function automatic t_out_word fifo_result(t_in_word w);
        t_out_word  r;
        int         c;
        logic [7:0] h0, h1, h2, h3, dummy;
        r = '0;
        r.status = ST_ACCEPTED;
        case (w.op)
            OP_PUT: begin
                if (!pkt_open) begin
                    if (ring_fill >= Depth) begin
                        r.status = ST_DROPPED;
                    end else begin
                        len_slot = wr_ptr;
                        pkt_len  = 0;
                        pkt_open = 1'b1;
                        void'(ring_push(8'd0));
                    end
                end
                if (pkt_open) begin
                    if (pkt_len >= LEN_CAP || !ring_push(w.data)) begin
                        r.status = ST_DROPPED;
                    end
                end
            end
            OP_END: begin
                if (pkt_open) begin
                    ring_mem[len_slot] = pkt_len[7:0];
                    pkt_open = 1'b0;
                    pkt_len  = 0;
                end else begin
                    r.status = ST_NOT_READY;
                end
            end
            OP_CHECK: begin
                if (pay_left != 0 || ring_fill == 0) begin
                    r.status = ST_NOT_READY;
                end else begin
                    c = ring_mem[rd_ptr];
                    if (c == 0) begin
                        r.status = ST_NOT_READY;
                    end else if (c < MIN_LEN) begin
                        ring_drop(c);
                        r.status = ST_DISCARDED;
                    end else begin
                        dummy = ring_pop();
                        h0 = ring_pop();
                        h1 = ring_pop();
                        h2 = ring_pop();
                        h3 = ring_pop();
                        if ((h0 ^ h2) != 8'hFF || (h1 ^ h3) != 8'hFF) begin
                            ring_drop(c - MIN_LEN);
                            r.status = ST_DISCARDED;
                        end else begin
                            r.packet_id = {h0, h1};
                            pay_left = c - MIN_LEN;
                            r.status = ST_VALID;
                        end
                    end
                end
            end
            default: begin
                if (pay_left == 0) begin
                    r.status = ST_NO_PAYLOAD;
                end else begin
                    r.tx_byte = ring_pop();
                    pay_left--;
                    r.last = (pay_left == 0);
                end
            end
        endcase
        return r;
    endfunction

    // Send one word, with an occasional idle burst first, and predict it.
    task automatic send_word(logic [1:0] op, logic [7:0] data);
        t_in_word w;
        int       gap;
        w.op   = op;
        w.data = data;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        result_q.push_back(fifo_result(w));
    endtask

    // Build one packet: kind 0 good, 1 broken id, 2 too short.
    task automatic send_packet(int npay, int kind);
        logic [7:0] a, b;
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        if (kind == 2) begin
            repeat ($urandom_range(0, 3)) send_word(OP_PUT, 8'($urandom_range(0, 255)));
        end else begin
            send_word(OP_PUT, a);
            send_word(OP_PUT, b);
            send_word(OP_PUT, (kind == 1) ? ~a ^ (8'd1 << $urandom_range(0, 7)) : ~a);
            send_word(OP_PUT, ~b);
            repeat (npay) send_word(OP_PUT, 8'($urandom_range(0, 255)));
        end
        send_word(OP_END, 8'd0);
    endtask

    // Empty the ring: check each head packet and pull its payload.
    task automatic drain_all();
        while (ring_fill > 0 && !pkt_open) begin
            send_word(OP_CHECK, 8'd0);
            while (pay_left > 0) begin
                send_word(OP_PULL, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Result word checking and output stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_word);
                    errors++;
                end else if (o_word.status !== result_q[0].status
                        || o_word.packet_id !== result_q[0].packet_id
                        || o_word.tx_byte !== result_q[0].tx_byte
                        || o_word.last !== result_q[0].last) begin
                    $display("%0t: expected %h actual %h", $time, result_q[0], o_word);
                    errors++;
                    void'(result_q.pop_front());
                end else begin
                    void'(result_q.pop_front());
                end
            end
            if (hold_start) begin
                hold_start = 1'b0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                i_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                stall_cnt = $urandom_range(1, 14) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Each op in its simple and corner forms.
    task automatic test_directed();
        send_word(OP_PULL, 8'hFF);
        send_word(OP_END, 8'h00);
        send_word(OP_CHECK, 8'h00);
        send_word(OP_PUT, 8'h00);
        send_word(OP_CHECK, 8'h00);
        send_word(OP_PUT, 8'hFF);
        send_word(OP_PUT, 8'hFF);
        send_word(OP_PUT, 8'h00);
        send_word(OP_END, 8'h00);
        send_word(OP_CHECK, 8'h00);
        send_word(OP_PULL, 8'h00);
        send_packet(2, 0);
        send_word(OP_CHECK, 8'h00);
        send_word(OP_CHECK, 8'h00);
        send_word(OP_PULL, 8'h00);
        send_word(OP_PULL, 8'h00);
        send_word(OP_PULL, 8'h00);
        send_packet(0, 2);
        send_word(OP_CHECK, 8'h00);
        send_packet(1, 1);
        send_word(OP_CHECK, 8'h00);
    endtask

    // Fill the ring to the brim behind a long output hold-off.
    task automatic test_full_ring();
        hold_start = 1'b1;
        send_packet(251, 0);
        repeat (5) send_word(OP_PUT, 8'($urandom_range(0, 255)));
        send_word(OP_END, 8'd0);
        send_packet(250, 1);
        send_word(OP_PUT, 8'hA5);
        send_word(OP_END, 8'd0);
        send_word(OP_PUT, 8'h5A);
        send_word(OP_PUT, 8'h3C);
        send_word(OP_END, 8'd0);
        send_word(OP_PUT, 8'hC3);
        drain_all();
    endtask

    // Random packets with some noise words.
    task automatic test_random(int n_packets);
        int k;
        for (int p = 0; p < n_packets; p++) begin
            k = $urandom_range(0, 9);
            send_packet($urandom_range(0, 10), (k < 7) ? 0 : (k < 9) ? 1 : 2);
            if ($urandom_range(0, 2) == 0) begin
                send_packet($urandom_range(0, 4), 0);
            end
            if ($urandom_range(0, 4) == 0) begin
                send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            send_word(OP_CHECK, 8'd0);
            repeat (pay_left + $urandom_range(0, 1)) begin
                send_word(OP_PULL, 8'($urandom_range(0, 255)));
            end
            if (pkt_open) begin
                send_word(OP_END, 8'd0);
            end
        end
        drain_all();
    endtask

    // Main sequence.
    initial begin
        errors     = 0;
        no_idle    = 1'b0;
        hold_start = 1'b0;
        hold_cnt   = 0;
        stall_cnt  = 0;
        wr_ptr     = '0;
        rd_ptr     = '0;
        ring_fill  = 0;
        pkt_open   = 1'b0;
        len_slot   = '0;
        pkt_len    = 0;
        pay_left   = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_word  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_ring();
        test_random(10);
        no_idle = 1'b1;
        test_random(5);
        i_valid <= 1'b0;
        wait (result_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
